// ===== design/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdp_pkg
// Types and constants shared by the time-of-day text parser modules.
// ----------------------------------------------------------------------------
package tdp_pkg;

	typedef enum logic [1:0] {
		MODE_24H = 2'd0,
		MODE_12H = 2'd1,
		MODE_DEC = 2'd2,
		MODE_RSV = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_HOUR   = 3'd0,
		PH_MIN    = 3'd1,
		PH_SEC    = 3'd2,
		PH_WS     = 3'd3,
		PH_LETTER = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		SUF_NONE = 3'd0,
		SUF_A    = 3'd1,
		SUF_P    = 3'd2,
		SUF_AM   = 3'd3,
		SUF_PM   = 3'd4
	} suffix_t;

	typedef enum logic [1:0] {
		ST_SCAN  = 2'd0,
		ST_CHECK = 2'd1,
		ST_MUL   = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic scan;
		logic check;
		logic load;
	} tdp_cmd_t;

	localparam int unsigned MICROS_W = 37;
	localparam int unsigned FIELD_W  = 7;
	localparam int unsigned SUM_W    = 17;
	localparam int unsigned MULT_W   = 20;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_UP    = 8'h50;
	localparam logic [7:0] CH_LP    = 8'h70;
	localparam logic [7:0] CH_UM    = 8'h4d;
	localparam logic [7:0] CH_LM    = 8'h6d;

	localparam logic [FIELD_W-1:0] MAX_HOUR_24 = 7'd23;
	localparam logic [FIELD_W-1:0] MAX_HOUR_12 = 7'd12;
	localparam logic [FIELD_W-1:0] MAX_HOUR_DEC = 7'd9;
	localparam logic [FIELD_W-1:0] MAX_MIN_SEC = 7'd59;

	localparam logic [MULT_W-1:0] US_PER_SEC     = 20'd1000000;
	localparam logic [MULT_W-1:0] US_PER_DEC_SEC = 20'd864000;

	localparam logic [MICROS_W-1:0] DAY_MICROS = 37'd86400000000;

endpackage

// ===== design/tdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdp_ctrl
// Controller: sequences character scan, final check and conversion.
// ----------------------------------------------------------------------------
module tdp_ctrl
	import tdp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     last,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output tdp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        in_xfer;

	assign in_xfer = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SCAN: begin
				if (in_xfer && last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_SCAN;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_SCAN: begin
				in_stall = 1'b0;
				cmd.scan = in_xfer;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
			end
			ST_MUL: begin
				cmd.load = !out_valid_q || !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCAN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/tdp_dp.sv =====
// ----------------------------------------------------------------------------
// tdp_dp
// Datapath: field scanner, range checks, seconds sum and microsecond scaling.
// ----------------------------------------------------------------------------
module tdp_dp
	import tdp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	input  logic [7:0]          ch,
	input  tdp_cmd_t            cmd,
	output logic                valid_res,
	output logic [MICROS_W-1:0] micros_of_day
);

	mode_t               mode_q;
	phase_t              phase_q, phase_d;
	suffix_t             suf_q, suf_d;
	logic [FIELD_W-1:0]  fv_q, fv_d;
	logic [1:0]          cnt_q, cnt_d;
	logic [FIELD_W-1:0]  hour_q, hour_d;
	logic [FIELD_W-1:0]  min_q, min_d;
	logic [FIELD_W-1:0]  sec_q, sec_d;
	logic                err_q, err_d;

	logic                is_digit, is_ws, is_a, is_p, is_m;
	logic [3:0]          digit;
	logic [10:0]         fv_mul;

	logic [FIELD_W-1:0]  m_eff, s_eff, h_adj;
	logic                shape_ok, ok;
	logic [20:0]         sum_wide;
	logic [SUM_W-1:0]    sum_q;
	logic                dec_q;
	logic                ok_q;
	logic [MULT_W-1:0]   mult;
	logic [MICROS_W-1:0] prod;
	logic [MICROS_W-1:0] micros_q;
	logic                valid_res_q;

	assign is_digit = (ch >= CH_0) && (ch <= CH_9);
	assign digit    = 4'(ch - CH_0);
	assign is_ws    = (ch == CH_SPACE) || (ch == CH_TAB);
	assign is_a     = (ch == CH_UA) || (ch == CH_LA);
	assign is_p     = (ch == CH_UP) || (ch == CH_LP);
	assign is_m     = (ch == CH_UM) || (ch == CH_LM);
	assign fv_mul   = 11'(fv_q) * 11'd10 + 11'(digit);

	// character scanner
	always_comb begin
		phase_d = phase_q;
		suf_d   = suf_q;
		fv_d    = fv_q;
		cnt_d   = cnt_q;
		hour_d  = hour_q;
		min_d   = min_q;
		sec_d   = sec_q;
		err_d   = err_q;
		if (cmd.check) begin
			phase_d = PH_HOUR;
			suf_d   = SUF_NONE;
			fv_d    = '0;
			cnt_d   = '0;
			hour_d  = '0;
			min_d   = '0;
			sec_d   = '0;
			err_d   = 1'b0;
		end else if (cmd.scan && !err_q) begin
			case (phase_q) inside
				PH_HOUR, PH_MIN, PH_SEC: begin
					if (is_digit) begin
						if (cnt_q == 2'd2) begin
							err_d = 1'b1;
						end else begin
							fv_d  = fv_mul[FIELD_W-1:0];
							cnt_d = cnt_q + 2'd1;
						end
					end else if (ch == CH_COLON) begin
						if (cnt_q == 2'd0 || phase_q == PH_SEC) begin
							err_d = 1'b1;
						end else begin
							if (phase_q == PH_HOUR) begin
								hour_d  = fv_q;
								phase_d = PH_MIN;
							end else begin
								min_d   = fv_q;
								phase_d = PH_SEC;
							end
							fv_d  = '0;
							cnt_d = '0;
						end
					end else if (mode_q == MODE_12H && phase_q != PH_HOUR
						&& cnt_q != 2'd0) begin
						if (phase_q == PH_MIN) begin
							min_d = fv_q;
						end else begin
							sec_d = fv_q;
						end
						fv_d  = '0;
						cnt_d = '0;
						if (is_ws) begin
							phase_d = PH_WS;
						end else if (is_a) begin
							suf_d   = SUF_A;
							phase_d = PH_LETTER;
						end else if (is_p) begin
							suf_d   = SUF_P;
							phase_d = PH_LETTER;
						end else begin
							err_d = 1'b1;
						end
					end else begin
						err_d = 1'b1;
					end
				end
				PH_WS: begin
					if (is_a) begin
						suf_d   = SUF_A;
						phase_d = PH_LETTER;
					end else if (is_p) begin
						suf_d   = SUF_P;
						phase_d = PH_LETTER;
					end else if (!is_ws) begin
						err_d = 1'b1;
					end
				end
				PH_LETTER: begin
					if (is_m) begin
						suf_d   = (suf_q == SUF_P) ? SUF_PM : SUF_AM;
						phase_d = PH_DONE;
					end else begin
						err_d = 1'b1;
					end
				end
				default: begin
					err_d = 1'b1;
				end
			endcase
		end
	end

	// final checks and seconds sum
	always_comb begin
		m_eff    = (mode_q != MODE_12H && phase_q == PH_MIN) ? fv_q : min_q;
		s_eff    = (mode_q != MODE_12H && phase_q == PH_SEC) ? fv_q : sec_q;
		shape_ok = (phase_q == PH_MIN || phase_q == PH_SEC) && cnt_q != 2'd0;
		h_adj    = (mode_q == MODE_12H && hour_q == MAX_HOUR_12) ? '0 : hour_q;
		if (mode_q == MODE_12H && suf_q == SUF_PM) begin
			h_adj = h_adj + 7'd12;
		end
		ok = 1'b0;
		unique case (mode_q)
			MODE_24H: ok = shape_ok && hour_q <= MAX_HOUR_24
				&& m_eff <= MAX_MIN_SEC && s_eff <= MAX_MIN_SEC;
			MODE_12H: ok = phase_q == PH_DONE && hour_q != '0
				&& hour_q <= MAX_HOUR_12 && m_eff <= MAX_MIN_SEC
				&& s_eff <= MAX_MIN_SEC;
			MODE_DEC: ok = shape_ok && hour_q <= MAX_HOUR_DEC;
			default:  ok = 1'b0;
		endcase
		ok = ok && !err_q;
		if (mode_q == MODE_DEC) begin
			sum_wide = 21'(hour_q) * 21'd10000 + 21'(m_eff) * 21'd100 + 21'(s_eff);
		end else begin
			sum_wide = 21'(h_adj) * 21'd3600 + 21'(m_eff) * 21'd60 + 21'(s_eff);
		end
	end

	assign mult = dec_q ? US_PER_DEC_SEC : US_PER_SEC;
	assign prod = MICROS_W'(sum_q) * MICROS_W'(mult);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_24H;
			phase_q <= PH_HOUR;
			suf_q   <= SUF_NONE;
			fv_q    <= '0;
			cnt_q   <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= mode_t'(cfg_wdata);
			end
			phase_q <= phase_d;
			suf_q   <= suf_d;
			fv_q    <= fv_d;
			cnt_q   <= cnt_d;
			hour_q  <= hour_d;
			min_q   <= min_d;
			sec_q   <= sec_d;
			err_q   <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			dec_q       <= 1'b0;
			ok_q        <= 1'b0;
			valid_res_q <= 1'b0;
			micros_q    <= '0;
		end else begin
			if (cmd.check) begin
				sum_q <= sum_wide[SUM_W-1:0];
				dec_q <= (mode_q == MODE_DEC);
				ok_q  <= ok;
			end
			if (cmd.load) begin
				valid_res_q <= ok_q;
				micros_q    <= ok_q ? prod : '0;
			end
		end
	end

	assign valid_res     = valid_res_q;
	assign micros_of_day = micros_q;

endmodule

// ===== design/time_of_day_text_parser.sv =====
// ----------------------------------------------------------------------------
// time_of_day_text_parser
// Parses an ASCII H:M[:S] time string (24-hour, 12-hour AM/PM or decimal)
// one character per transfer and returns the microseconds of the day.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, ch, last          | sink
//  out     | out_valid, out_stall, valid_res,      | source
//          | micros_of_day                         |
//  cfg     | cfg_we, cfg_wdata (time_mode)         | sink
//
//  a character that is not last is taken without a stall, back to back
//  a last character holds in_stall through the range check and seconds
//  sum, then through the multiply into the output register
//  the multiply waits while an earlier result is still stalled at the output
//  arst_n clears the parser state, the output register and sets 24-hour mode
// ----------------------------------------------------------------------------
module time_of_day_text_parser
	import tdp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          ch,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                valid_res,
	output logic [MICROS_W-1:0] micros_of_day
);

	tdp_cmd_t cmd;

	tdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tdp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.ch            (ch),
		.cmd           (cmd),
		.valid_res     (valid_res),
		.micros_of_day (micros_of_day)
	);

endmodule

// ===== design/tdp_checker.sv =====
// ----------------------------------------------------------------------------
// tdp_checker
// Port-level checks for the time-of-day text parser, bound to the top level.
// ----------------------------------------------------------------------------
module tdp_checker
	import tdp_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_we,
	input logic [1:0]          cfg_wdata,
	input logic                in_valid,
	input logic                in_stall,
	input logic [7:0]          ch,
	input logic                last,
	input logic                out_valid,
	input logic                out_stall,
	input logic                valid_res,
	input logic [MICROS_W-1:0] micros_of_day
);

	// a final character blocks input for the check and multiply cycles
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last) |=> in_stall ##1 in_stall)
		else $error("input not held off after final character");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> (micros_of_day == '0))
		else $error("invalid result with nonzero time");

	a_in_day: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (micros_of_day < DAY_MICROS))
		else $error("time beyond one day");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(valid_res) && $stable(micros_of_day)))
		else $error("stalled result changed");

endmodule

bind time_of_day_text_parser tdp_checker u_tdp_checker (.*);
